// ===== hw/rtl/tlc_pkg.sv =====
// Shared types, register indexes and small helpers for the two-axis
// traffic light controller. No dependencies.

package tlc_pkg;

  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;
  localparam int COUNT_W    = 9;

  typedef enum logic [1:0] {
    PH_GREEN = 2'd0,
    PH_AMBER = 2'd1,
    PH_RED   = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    REG_INIT_GREEN = 2'd0,
    REG_AMBER      = 2'd1,
    REG_ALL_RED    = 2'd2
  } reg_idx_t;

  localparam logic [7:0] INIT_GREEN_RST = 8'd10;
  localparam logic [3:0] AMBER_RST      = 4'd3;
  localparam logic [3:0] ALL_RED_RST    = 4'd2;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef struct packed {
    logic [7:0] green_time_ns;
    logic [7:0] green_time_ew;
  } in_word_t;

  typedef struct packed {
    logic [1:0]         ns_color;
    logic [1:0]         ew_color;
    logic [COUNT_W-1:0] ns_remaining;
    logic [COUNT_W-1:0] ew_remaining;
  } out_word_t;

  typedef struct packed {
    logic [7:0] initial_green_ns;
    logic [3:0] amber_time;
    logic [3:0] all_red_time;
  } cfg_t;

  function automatic logic [COUNT_W-1:0] sat_count(input logic [COUNT_W:0] v);
    sat_count = v[COUNT_W] ? COUNT_MAX : v[COUNT_W-1:0];
  endfunction

  function automatic logic [7:0] nz8(input logic [7:0] v);
    nz8 = (v == 8'd0) ? 8'd1 : v;
  endfunction

  function automatic logic [3:0] nz4(input logic [3:0] v);
    nz4 = (v == 4'd0) ? 4'd1 : v;
  endfunction

endpackage

// ===== hw/rtl/tlc_cfg.sv =====
// APB-style register file: initial green, amber and all-red times.
// Depends on tlc_pkg.

module tlc_cfg import tlc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output cfg_t                  cfg
);

  cfg_t     cfg_r, cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign idx   = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);
  assign wr_en = psel & penable & pwrite;

  always_comb begin
    cfg_nxt = cfg_r;
    prdata  = '0;
    case (idx)
      REG_INIT_GREEN: begin
        if (wr_en) cfg_nxt.initial_green_ns = pwdata[7:0];
        prdata = {24'd0, cfg_r.initial_green_ns};
      end
      REG_AMBER: begin
        if (wr_en) cfg_nxt.amber_time = pwdata[3:0];
        prdata = {28'd0, cfg_r.amber_time};
      end
      REG_ALL_RED: begin
        if (wr_en) cfg_nxt.all_red_time = pwdata[3:0];
        prdata = {28'd0, cfg_r.all_red_time};
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{initial_green_ns: INIT_GREEN_RST, amber_time: AMBER_RST,
                 all_red_time: ALL_RED_RST};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== hw/rtl/tlc_axis.sv =====
// Phase advance for one axis: when the count has run out, move to the
// next colour and load its duration. Depends on tlc_pkg.

module tlc_axis import tlc_pkg::*; (
  input  phase_t             phase_i,
  input  logic [COUNT_W-1:0] count_i,
  input  logic [7:0]         own_green,
  input  logic [7:0]         other_green,
  input  cfg_t               cfg,
  output phase_t             phase_o,
  output logic [COUNT_W-1:0] count_o
);

  logic [3:0]       amber_eff;
  logic [COUNT_W:0] red_sum;

  assign amber_eff = nz4(cfg.amber_time);
  assign red_sum   = {2'd0, other_green} + {6'd0, amber_eff}
                   + {5'd0, cfg.all_red_time, 1'b0};

  always_comb begin
    phase_o = phase_i;
    count_o = count_i;
    if (count_i == '0) begin
      case (phase_i)
        PH_GREEN: begin
          phase_o = PH_AMBER;
          count_o = {5'd0, amber_eff};
        end
        PH_AMBER: begin
          phase_o = PH_RED;
          count_o = sat_count(red_sum);
        end
        default: begin
          phase_o = PH_GREEN;
          count_o = {1'b0, own_green};
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/two_axis_traffic_light_controller_core.sv =====
// Two-axis traffic light controller: top level with input and result
// registers, phase and count state. Depends on tlc_pkg, tlc_cfg, tlc_axis.
//
//  channel | handshake          | payload
//  in      | in_valid/in_stall  | in_data  (in_word_t: green times)
//  out     | out_valid/out_stall| out_data (out_word_t: colours, counts)
//  cfg     | psel/penable/pwrite| paddr, pwdata, prdata, pready
//
// One word in and one word out per cycle unless out_stall holds them,
// limited by the phase update loop (input register, then result register).
// Synchronous active-low reset; counts load from the registers on the
// first tick. A stalled result holds and backs up into the input register.

module two_axis_traffic_light_controller_core import tlc_pkg::*; #(
  parameter int DURATION_BITS = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_word_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_word_t             out_data,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int         MASK_W   = (DURATION_BITS < 8) ? DURATION_BITS : 8;
  localparam logic [7:0] DUR_MASK = 8'((16'd1 << MASK_W) - 16'd1);

  cfg_t               cfg;
  logic               s1_valid_r, s1_valid_nxt;
  in_word_t           s1_data_r;
  logic               out_valid_r, out_valid_nxt;
  out_word_t          out_data_r, out_data_nxt;
  logic               started_r, started_nxt;
  phase_t             ns_phase_r, ns_phase_nxt, ew_phase_r, ew_phase_nxt;
  logic [COUNT_W-1:0] ns_count_r, ns_count_nxt, ew_count_r, ew_count_nxt;
  logic [COUNT_W-1:0] ns_cur, ew_cur, ns_shown, ew_shown;
  logic [7:0]         gns, gew, g0;
  logic [COUNT_W:0]   ew_start;
  logic               adv, in_acc, fire;

  tlc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  assign pready = 1'b1;

  assign adv      = ~out_valid_r | ~out_stall;
  assign in_stall = s1_valid_r & ~adv;
  assign in_acc   = in_valid & ~in_stall;
  assign fire     = s1_valid_r & adv;

  assign gns      = nz8(s1_data_r.green_time_ns & DUR_MASK);
  assign gew      = nz8(s1_data_r.green_time_ew & DUR_MASK);
  assign g0       = nz8(cfg.initial_green_ns);
  assign ew_start = {2'd0, g0} + {6'd0, nz4(cfg.amber_time)} + {6'd0, cfg.all_red_time};
  assign ns_cur   = started_r ? ns_count_r : {1'b0, g0};
  assign ew_cur   = started_r ? ew_count_r : sat_count(ew_start);

  tlc_axis u_ns (
    .phase_i     (ns_phase_r),
    .count_i     (ns_cur),
    .own_green   (gns),
    .other_green (gew),
    .cfg         (cfg),
    .phase_o     (ns_phase_nxt),
    .count_o     (ns_shown)
  );

  tlc_axis u_ew (
    .phase_i     (ew_phase_r),
    .count_i     (ew_cur),
    .own_green   (gew),
    .other_green (gns),
    .cfg         (cfg),
    .phase_o     (ew_phase_nxt),
    .count_o     (ew_shown)
  );

  always_comb begin
    ns_count_nxt = (ns_shown != '0) ? ns_shown - COUNT_W'(1) : ns_shown;
    ew_count_nxt = (ew_shown != '0) ? ew_shown - COUNT_W'(1) : ew_shown;
    started_nxt  = 1'b1;
    s1_valid_nxt = in_acc | (s1_valid_r & ~adv);
    out_valid_nxt = fire | (out_valid_r & out_stall);
    out_data_nxt.ns_color     = (ns_phase_nxt == PH_GREEN || ns_phase_nxt == PH_AMBER) ?
                                ns_phase_nxt : PH_RED;
    out_data_nxt.ew_color     = (ew_phase_nxt == PH_GREEN || ew_phase_nxt == PH_AMBER) ?
                                ew_phase_nxt : PH_RED;
    out_data_nxt.ns_remaining = ns_shown;
    out_data_nxt.ew_remaining = ew_shown;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      started_r   <= 1'b0;
      ns_phase_r  <= PH_GREEN;
      ew_phase_r  <= PH_RED;
      ns_count_r  <= '0;
      ew_count_r  <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (fire) begin
        started_r  <= started_nxt;
        ns_phase_r <= ns_phase_nxt;
        ew_phase_r <= ew_phase_nxt;
        ns_count_r <= ns_count_nxt;
        ew_count_r <= ew_count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_data_r <= in_data;
    end
    if (fire) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== hw/rtl/tlc_chk.sv =====
// Port-level checker for the traffic light controller, bound to the top
// level. Depends on tlc_pkg.

module tlc_chk import tlc_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_stall,
  input out_word_t out_data
);

  a_colour_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.ns_color != 2'd3 && out_data.ew_color != 2'd3))
    else $error("colour code out of range");

  a_count_live: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.ns_remaining != '0 && out_data.ew_remaining != '0))
    else $error("shown count is zero");

  a_amber_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.ns_color == PH_AMBER) |-> out_data.ns_remaining <= 9'd15)
    else $error("amber count exceeds amber range");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result word changed");

endmodule

bind two_axis_traffic_light_controller_core tlc_chk u_tlc_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
